FILE: rtl/ogru_pkg.sv
package ogru_pkg;

    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 256;

    localparam int COORD_W     = 12;
    localparam int RANGE_W     = 16;
    localparam int STEP_W      = 7;
    localparam int ODDS_W      = 8;
    localparam int COUNT_W     = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 24;
    localparam int SUM_W       = ODDS_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_STEP = 2'd2;

    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 16'd5000;
    localparam logic [STEP_W-1:0]  HIT_STEP_RST  = 7'd3;
    localparam logic [STEP_W-1:0]  MISS_STEP_RST = 7'd1;

    localparam logic signed [SUM_W-1:0] ODDS_HI = 10'sd127;
    localparam logic signed [SUM_W-1:0] ODDS_LO = -10'sd127;

    typedef struct packed {
        logic clr_wr;
        logic latch;
        logic init_a;
        logic init_b;
        logic addr_ld;
        logic sel_end;
        logic mem_rd;
        logic hit_wr;
        logic miss_wr;
        logic step;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic at_end;
    } t_sts;

    function automatic logic signed [ODDS_W-1:0] clamp_odds(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (c > ODDS_HI) c = ODDS_HI;
        if (c < ODDS_LO) c = ODDS_LO;
        return c[ODDS_W-1:0];
    endfunction

endpackage

FILE: rtl/ogru_ctrl.sv
module ogru_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_mode,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ogru_pkg::t_cmd o_cmd,
    input  ogru_pkg::t_sts i_sts
);
    import ogru_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EADDR = 4'd2;
    localparam logic [3:0] S_HRD   = 4'd3;
    localparam logic [3:0] S_HWR   = 4'd4;
    localparam logic [3:0] S_LADDR = 4'd5;
    localparam logic [3:0] S_LRD   = 4'd6;
    localparam logic [3:0] S_LWR   = 4'd7;
    localparam logic [3:0] S_FADDR = 4'd8;
    localparam logic [3:0] S_FRD   = 4'd9;
    localparam logic [3:0] S_FDAT  = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = i_in_mode ? S_FADDR : S_EADDR;
                end
            end
            S_EADDR: begin
                o_cmd.init_a  = 1'b1;
                o_cmd.addr_ld = 1'b1;
                o_cmd.sel_end = 1'b1;
                n_state = S_HRD;
            end
            S_HRD: begin
                o_cmd.init_b = 1'b1;
                o_cmd.mem_rd = 1'b1;
                n_state = S_HWR;
            end
            S_HWR: begin
                o_cmd.hit_wr = 1'b1;
                n_state = S_LADDR;
            end
            S_LADDR: begin
                o_cmd.addr_ld = 1'b1;
                n_state = S_LRD;
            end
            S_LRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_LWR;
            end
            S_LWR: begin
                o_cmd.miss_wr = 1'b1;
                if (i_sts.at_end) begin
                    n_state = S_FADDR;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = S_LADDR;
                end
            end
            S_FADDR: begin
                o_cmd.addr_ld = 1'b1;
                o_cmd.sel_end = !i_sts.is_read;
                n_state = S_FRD;
            end
            S_FRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_FDAT;
            end
            S_FDAT: begin
                if (out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_ld) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/ogru_dp.sv
module ogru_dp #(
    parameter int GRID_WIDTH  = ogru_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogru_pkg::GRID_HEIGHT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ogru_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ogru_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic [ogru_pkg::IN_TDATA_W-1:0]      i_in_data,
    input  logic                                 i_in_mode,
    input  ogru_pkg::t_cmd                       i_cmd,
    output ogru_pkg::t_sts                       o_sts,
    output logic [ogru_pkg::OUT_TDATA_W-1:0]     o_out_data,
    output logic                                 o_out_in_grid
);
    import ogru_pkg::*;

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int MULW  = 2 * COORD_W;
    localparam logic [COORD_W-1:0] GW = COORD_W'(GRID_WIDTH);
    localparam logic [COORD_W-1:0] GH = COORD_W'(GRID_HEIGHT);

    logic [ODDS_W-1:0] mem [DEPTH];

    logic [RANGE_W-1:0] r_max_range;
    logic [STEP_W-1:0]  r_hit_step, r_miss_step;

    logic                       r_mode;
    logic signed [COORD_W-1:0]  r_cur_x, r_cur_y, r_end_x, r_end_y;
    logic [RANGE_W-1:0]         r_range;
    logic [COORD_W:0]           r_dx;
    logic signed [COORD_W+1:0]  r_dy;
    logic                       r_xneg, r_yneg;
    logic signed [COORD_W+2:0]  r_err;
    logic [AW-1:0]              r_addr;
    logic                       r_in, r_hit;
    logic signed [ODDS_W-1:0]   r_rdata;
    logic [COUNT_W-1:0]         r_count;
    logic [AW-1:0]              r_clr;
    logic signed [ODDS_W-1:0]   r_o_value;
    logic [COUNT_W-1:0]         r_o_count;
    logic                       r_o_in;

    logic signed [COORD_W:0]    diff_x, diff_y;
    logic [COORD_W-1:0]         ax, ay;
    logic                       a_in;
    logic [MULW-1:0]            addr_sum;
    logic signed [COORD_W+3:0]  e2;
    logic                       step_x, step_y;
    logic signed [COORD_W+2:0]  dx_s, dy_s;
    logic                       we;
    logic [AW-1:0]              wa;
    logic [ODDS_W-1:0]          wd;

    assign diff_x = {r_end_x[COORD_W-1], r_end_x} - {r_cur_x[COORD_W-1], r_cur_x};
    assign diff_y = {r_end_y[COORD_W-1], r_end_y} - {r_cur_y[COORD_W-1], r_cur_y};

    assign ax   = i_cmd.sel_end ? r_end_x : r_cur_x;
    assign ay   = i_cmd.sel_end ? r_end_y : r_cur_y;
    assign a_in = !ax[COORD_W-1] && (ax < GW) && !ay[COORD_W-1] && (ay < GH);
    assign addr_sum = ({{COORD_W{1'b0}}, ay} * {{COORD_W{1'b0}}, GW}) + {{COORD_W{1'b0}}, ax};

    assign dx_s   = $signed({2'b00, r_dx});
    assign dy_s   = (COORD_W+3)'(r_dy);
    assign e2     = {r_err, 1'b0};
    assign step_x = e2 >= (COORD_W+4)'(dy_s);
    assign step_y = e2 <= (COORD_W+4)'(dx_s);

    assign we = i_cmd.clr_wr | (i_cmd.hit_wr & r_hit) | (i_cmd.miss_wr & r_in);
    assign wa = i_cmd.clr_wr ? r_clr : r_addr;

    always_comb begin
        if (i_cmd.clr_wr) begin
            wd = '0;
        end else if (i_cmd.hit_wr) begin
            wd = clamp_odds(SUM_W'(r_rdata) + $signed({3'b000, r_hit_step}));
        end else begin
            wd = clamp_odds(SUM_W'(r_rdata) - $signed({3'b000, r_miss_step}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (i_cmd.mem_rd) r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= MAX_RANGE_RST;
            r_hit_step  <= HIT_STEP_RST;
            r_miss_step <= MISS_STEP_RST;
            r_clr       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_RANGE: r_max_range <= i_cfg_wdata;
                    CFG_HIT_STEP:  r_hit_step  <= i_cfg_wdata[STEP_W-1:0];
                    CFG_MISS_STEP: r_miss_step <= i_cfg_wdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_wr) r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode  <= i_in_mode;
            r_cur_x <= i_in_data[11:0];
            r_cur_y <= i_in_data[23:12];
            r_end_x <= i_in_data[35:24];
            r_end_y <= i_in_data[47:36];
            r_range <= i_in_data[63:48];
            r_count <= '0;
        end
        if (i_cmd.init_a) begin
            r_dx   <= diff_x[COORD_W] ? -diff_x : diff_x;
            r_dy   <= diff_y[COORD_W] ? (COORD_W+2)'(diff_y) : -(COORD_W+2)'(diff_y);
            r_xneg <= !(r_cur_x < r_end_x);
            r_yneg <= !(r_cur_y < r_end_y);
        end
        if (i_cmd.init_b) begin
            r_err <= dx_s + dy_s;
            r_hit <= (r_range < r_max_range) && r_in;
        end
        if (i_cmd.addr_ld) begin
            r_addr <= addr_sum[AW-1:0];
            r_in   <= a_in;
        end
        if (i_cmd.miss_wr && r_in) r_count <= r_count + 1'b1;
        if (i_cmd.step) begin
            r_err <= r_err + (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
            if (step_x) r_cur_x <= r_xneg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
            if (step_y) r_cur_y <= r_yneg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
        end
        if (i_cmd.out_ld) begin
            r_o_value <= r_in ? r_rdata : '0;
            r_o_count <= r_count;
            r_o_in    <= r_in;
        end
    end

    assign o_sts.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_sts.is_read  = r_mode;
    assign o_sts.at_end   = (r_cur_x == r_end_x) && (r_cur_y == r_end_y);

    assign o_out_data    = {3'b000, r_o_count, r_o_value};
    assign o_out_in_grid = r_o_in;

endmodule

FILE: rtl/occupancy_grid_ray_update_unit.sv
// Occupancy grid ray update unit.
// Holds a GRID_WIDTH x GRID_HEIGHT grid of signed 8-bit log-odds cells in one
// single-port memory. Input items arrive on the s_axis channel: tuser selects
// a ray (0) or a cell read (1), tdata carries start, end and range. Each item
// produces exactly one result item on the m_axis channel.
// Config: i_cfg_we/i_cfg_idx/i_cfg_wdata write max_range (0), hit_step (1),
// miss_step (2); write only while the unit is idle.
// Sequence: a read item passes an address, a read and an output state; a
// ray first updates its end cell (address, read, write back), walks its line
// and then reads its end cell back; the unit is ready again as the result
// becomes valid. The grid memory has one port, and every line cell costs an
// address step (multiply), a read and a write back.
// One item is in work at a time; the next is accepted once the result is in
// the output register, so a stalled receiver costs nothing until the
// following result is ready.
// Reset: config returns to 5000/3/1 and a clearing pass writes zero to every
// cell, one per cycle, GRID_WIDTH*GRID_HEIGHT cells (65536 by default);
// s_axis tready stays low during that pass. Results hold while tready is low.
module occupancy_grid_ray_update_unit #(
    parameter int GRID_WIDTH  = ogru_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogru_pkg::GRID_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ogru_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ogru_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], range_mm[63:48]
    input  logic [ogru_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // mode[0]
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // cell_value[7:0], cells_updated[20:8], zero[23:21]
    output logic [ogru_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // cell_in_grid[0]
    output logic                               o_m_axis_tuser
);
    import ogru_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ogru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_mode   (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ogru_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_data     (i_s_axis_tdata),
        .i_in_mode     (i_s_axis_tuser),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_data    (o_m_axis_tdata),
        .o_out_in_grid (o_m_axis_tuser)
    );

endmodule

FILE: rtl/ogru_checker.sv
module ogru_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [ogru_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                             o_m_axis_tuser
);
    import ogru_pkg::*;

    a_rst_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second item taken while one is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_off_grid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[ODDS_W-1:0] == '0)
        else $error("off-grid result with nonzero cell value");

    a_odds_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[ODDS_W-1:0] != {1'b1, {(ODDS_W-1){1'b0}}})
        else $error("cell value out of clamp range");

endmodule

bind occupancy_grid_ray_update_unit ogru_checker u_ogru_checker (.*);

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ogru_pkg::*;

    typedef enum logic {
        MODE_RAY  = 1'b0,
        MODE_READ = 1'b1
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int MAP_W       = GRID_WIDTH_DEF;
    localparam int MAP_H       = GRID_HEIGHT_DEF;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 138;
    localparam int QUIET_LIMIT = 400000;

    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic [RANGE_W-1:0]        rng;
    } t_beam;

    typedef struct packed {
        logic signed [ODDS_W-1:0] odds;
        logic [COUNT_W-1:0]       count;
        logic                     in_grid;
    } t_cell_res;

    typedef struct packed {
        t_beam     b;
        logic      typed;
        t_cell_res res;
    } t_dir_row;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    logic signed [ODDS_W-1:0] odds_map [MAP_W*MAP_H];
    int lim_range;
    int hit_amt;
    int miss_amt;

    t_cell_res odds_due [$];
    t_dir_row  dir_rows [$];

    int send_gap_pct = 0;
    int stall_pct = 0;
    int bad_results = 0;
    int quiet_cycles = 0;

    always #2 clk = ~clk;

    occupancy_grid_ray_update_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    function automatic bit on_map(int x, int y);
        return x >= 0 && x < MAP_W && y >= 0 && y < MAP_H;
    endfunction

    function automatic logic signed [ODDS_W-1:0] sat_odds(int v);
        if (v > int'(ODDS_HI)) v = int'(ODDS_HI);
        if (v < int'(ODDS_LO)) v = int'(ODDS_LO);
        return v[ODDS_W-1:0];
    endfunction

    // hit on the end cell first, then walk the line and take miss_amt off each cell
    function automatic t_cell_res score_beam(t_beam b);
        int x0, y0, x1, y1, dx, dy, stx, sty, err, e2, k;
        bit done;
        t_cell_res r;
        x0 = int'(b.sx);
        y0 = int'(b.sy);
        x1 = int'(b.ex);
        y1 = int'(b.ey);
        r = '0;
        if (b.mode == MODE_READ) begin
            r.in_grid = on_map(x0, y0);
            if (r.in_grid) r.odds = odds_map[y0 * MAP_W + x0];
            return r;
        end
        r.in_grid = on_map(x1, y1);
        if (r.in_grid && b.rng < lim_range) begin
            k = y1 * MAP_W + x1;
            odds_map[k] = sat_odds(int'(odds_map[k]) + hit_amt);
        end
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y0 - y1 : y1 - y0;
        stx = (x0 < x1) ? 1 : -1;
        sty = (y0 < y1) ? 1 : -1;
        err = dx + dy;
        done = 1'b0;
        while (!done) begin
            if (on_map(x0, y0)) begin
                k = y0 * MAP_W + x0;
                odds_map[k] = sat_odds(int'(odds_map[k]) - miss_amt);
                r.count = r.count + 1'b1;
            end
            if (x0 == x1 && y0 == y1) begin
                done = 1'b1;
            end else begin
                e2 = 2 * err;
                if (e2 >= dy) begin
                    err += dy;
                    x0 += stx;
                end
                if (e2 <= dx) begin
                    err += dx;
                    y0 += sty;
                end
            end
        end
        if (r.in_grid) r.odds = odds_map[y1 * MAP_W + x1];
        return r;
    endfunction

    function automatic int near_edge();
        return ($urandom_range(0, 1) ? MAP_W - 24 : -8) + int'($urandom_range(0, 31));
    endfunction

    // mostly short rays and reads packed near the four grid corners so cells pile up
    function automatic t_beam rand_beam();
        t_beam b;
        int pick, cx, cy;
        pick = $urandom_range(0, 99);
        cx = near_edge();
        cy = near_edge();
        b.mode = MODE_RAY;
        b.sx = COORD_W'(cx);
        b.sy = COORD_W'(cy);
        b.ex = COORD_W'(cx + int'($urandom_range(0, 24)) - 12);
        b.ey = COORD_W'(cy + int'($urandom_range(0, 24)) - 12);
        case ($urandom_range(0, 2))
            0: b.rng = RANGE_W'($urandom);
            1: b.rng = RANGE_W'(lim_range - 1 + int'($urandom_range(0, 2)));
            default: b.rng = RANGE_W'($urandom_range(0, lim_range));
        endcase
        if (pick >= 92) begin
            b.ex = COORD_W'(cx + int'($urandom_range(0, 600)) - 300);
            b.ey = COORD_W'(cy + int'($urandom_range(0, 600)) - 300);
        end else if (pick >= 88) begin
            b.sx = COORD_W'($urandom);
            b.sy = COORD_W'($urandom);
            b.ex = COORD_W'($urandom);
            b.ey = COORD_W'($urandom);
        end else if (pick >= 80) begin
            b.mode = MODE_READ;
            b.sx = COORD_W'($urandom);
            b.sy = COORD_W'($urandom);
        end else if (pick >= 60) begin
            b.mode = MODE_READ;
        end
        return b;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] step_word(int s);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom);
        w[STEP_W-1:0] = STEP_W'(s);
        return w;
    endfunction

    task automatic add_row(input logic md, input int x0, input int y0, input int x1,
                           input int y1, input int rng, input bit typed,
                           input int odds = 0, input int cnt = 0, input int ing = 0);
        t_dir_row r;
        r.b.mode = md;
        r.b.sx = COORD_W'(x0);
        r.b.sy = COORD_W'(y0);
        r.b.ex = COORD_W'(x1);
        r.b.ey = COORD_W'(y1);
        r.b.rng = RANGE_W'(rng);
        r.typed = typed;
        r.res.odds = ODDS_W'(odds);
        r.res.count = COUNT_W'(cnt);
        r.res.in_grid = ing[0];
        dir_rows = {dir_rows, r};
    endtask

    // cfg_we is left high; the caller drops it after its last write
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_MAX_RANGE: lim_range = int'(val);
            CFG_HIT_STEP:  hit_amt = int'(val[STEP_W-1:0]);
            CFG_MISS_STEP: miss_amt = int'(val[STEP_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic offer_beam(input t_beam b);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= b.mode;
        s_tdata <= {b.rng, b.ey, b.ex, b.sy, b.sx};
        do @(posedge clk); while (!s_tready);
    endtask

    always @(posedge clk) begin : sink
        t_cell_res want;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("occupancy_grid_ray_update_unit regression: fail");
            $finish;
        end else if (rst_n && m_tvalid && m_tready) begin
            if (odds_due.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result item: tdata %h tuser %b", m_tdata, m_tuser);
            end else begin
                want = odds_due.pop_front();
                if (m_tdata[ODDS_W-1:0] !== want.odds
                        || m_tdata[ODDS_W +: COUNT_W] !== want.count
                        || m_tuser !== want.in_grid) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("mismatch: want odds %0d cells %0d in %0b, got odds %0d cells %0d in %0b",
                                 want.odds, want.count, want.in_grid,
                                 $signed(m_tdata[ODDS_W-1:0]), m_tdata[ODDS_W +: COUNT_W], m_tuser);
                end
            end
        end
    end

    initial begin : stim
        t_cell_res want;
        t_beam b;
        int k, ph;
        for (k = 0; k < MAP_W * MAP_H; k++) odds_map[k] = '0;
        lim_range = int'(MAX_RANGE_RST);
        hit_amt = int'(HIT_STEP_RST);
        miss_amt = int'(MISS_STEP_RST);

        add_row(MODE_READ, 0, 0, 0, 0, 0, 1, 0, 0, 1);
        add_row(MODE_READ, 255, 255, 0, 0, 65535, 1, 0, 0, 1);
        add_row(MODE_READ, 256, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(MODE_READ, -1, -1, -1, -1, 65535, 1, 0, 0, 0);
        add_row(MODE_READ, 2047, -2048, 2047, -2048, 0, 1, 0, 0, 0);
        add_row(MODE_READ, -2048, 2047, 0, 0, 0, 1, 0, 0, 0);
        add_row(MODE_RAY, 5, 5, 5, 5, 4999, 1, 2, 1, 1);
        add_row(MODE_RAY, 7, 7, 7, 7, 5000, 1, -1, 1, 1);
        add_row(MODE_RAY, -2048, -2048, -2048, -2048, 0, 1, 0, 0, 0);
        add_row(MODE_RAY, -100, -50, -10, -300, 100, 1, 0, 0, 0);
        add_row(MODE_RAY, 0, 40, 255, 40, 65535, 1, -1, 256, 1);
        add_row(MODE_RAY, -2048, -2048, 2047, 2047, 0, 1, 0, 256, 0);
        add_row(MODE_RAY, 2047, 0, 255, 0, 1, 1, 2, 1, 1);
        add_row(MODE_RAY, 0, 255, -2048, 255, 2, 1, 0, 1, 0);
        add_row(MODE_READ, 0, 255, 0, 0, 0, 1, -1, 0, 1);
        add_row(MODE_READ, 5, 5, 0, 0, 0, 0);
        add_row(MODE_RAY, 2047, 2047, -2048, -2048, 0, 0);
        add_row(MODE_RAY, 10, 100, 40, 90, 200, 0);
        add_row(MODE_RAY, 100, 10, 90, 60, 4000, 0);
        add_row(MODE_RAY, -30, -30, 3, 200, 10, 0);
        add_row(MODE_RAY, 0, 0, 255, 255, 65535, 0);
        add_row(MODE_READ, 0, 0, 0, 0, 0, 0);
        add_row(MODE_RAY, -1, 128, 256, 130, 4999, 0);
        add_row(MODE_READ, 128, 129, 0, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            offer_beam(dir_rows[i].b);
            want = score_beam(dir_rows[i].b);
            odds_due = {odds_due, (dir_rows[i].typed ? dir_rows[i].res : want)};
        end

        for (ph = 0; ph < PHASES; ph++) begin
            s_tvalid <= 1'b0;
            while (odds_due.size() != 0) @(posedge clk);
            case (ph)
                0: begin
                    put_reg(CFG_MAX_RANGE, 16'hFFFF);
                    put_reg(CFG_HIT_STEP, step_word(127));
                    put_reg(CFG_MISS_STEP, step_word(1));
                    send_gap_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    put_reg(CFG_MAX_RANGE, 16'h0000);
                    put_reg(CFG_HIT_STEP, step_word(5));
                    put_reg(CFG_MISS_STEP, step_word(127));
                    send_gap_pct = 51;
                    stall_pct = 0;
                end
                2: begin
                    put_reg(CFG_MAX_RANGE, 16'd300);
                    put_reg(CFG_HIT_STEP, step_word(0));
                    put_reg(CFG_MISS_STEP, step_word(0));
                    put_reg(CFG_SPARE, 16'h0001);
                    send_gap_pct = 0;
                    stall_pct = 51;
                end
                3: begin
                    put_reg(CFG_MAX_RANGE, CFG_DATA_W'($urandom));
                    put_reg(CFG_HIT_STEP, step_word($urandom_range(0, 127)));
                    put_reg(CFG_MISS_STEP, step_word($urandom_range(0, 127)));
                    send_gap_pct = 15;
                    stall_pct = 15;
                end
                4: begin
                    put_reg(CFG_MAX_RANGE, 16'd40000);
                    put_reg(CFG_HIT_STEP, step_word(127));
                    put_reg(CFG_MISS_STEP, step_word(127));
                    send_gap_pct = 0;
                    stall_pct = 0;
                end
                default: begin
                    put_reg(CFG_MAX_RANGE, 16'd1000);
                    put_reg(CFG_HIT_STEP, step_word(20));
                    put_reg(CFG_MISS_STEP, step_word(3));
                    send_gap_pct = 51;
                    stall_pct = 51;
                end
            endcase
            cfg_we <= 1'b0;
            repeat (PHASE_ITEMS) begin
                b = rand_beam();
                offer_beam(b);
                odds_due = {odds_due, score_beam(b)};
            end
        end

        s_tvalid <= 1'b0;
        while (odds_due.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (bad_results == 0 && odds_due.size() == 0) begin
            $display("occupancy_grid_ray_update_unit regression: pass");
        end else begin
            $display("occupancy_grid_ray_update_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ogru_pkg.sv
rtl/ogru_ctrl.sv
rtl/ogru_dp.sv
rtl/occupancy_grid_ray_update_unit.sv
rtl/ogru_checker.sv
bench/tb.sv
